### sv/mob_pkg.sv
package mob_pkg;

  localparam int MAX_LEN  = 128;
  localparam int ALPHABET = 256;

  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ALPHA_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INC,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic               en;
    logic [ALPHA_W-1:0] addr;
    logic [CNT_W-1:0]   data;
  } hist_wr_t;

endpackage

### sv/mob_buf.sv
module mob_buf (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mob_pkg::IDX_W-1:0]  wr_addr,
  input  logic [mob_pkg::BYTE_W-1:0] wr_data,
  input  logic [mob_pkg::IDX_W-1:0]  rd_addr,
  output logic [mob_pkg::BYTE_W-1:0] rd_data
);

  logic [mob_pkg::BYTE_W-1:0] mem [mob_pkg::MAX_LEN];
  logic [mob_pkg::BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/mob_hist.sv
module mob_hist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic [mob_pkg::ALPHA_W-1:0] rd_addr,
  input  mob_pkg::hist_wr_t           wr,
  output logic [mob_pkg::CNT_W-1:0]   rd_count
);

  logic [mob_pkg::CNT_W-1:0]    mem [mob_pkg::ALPHABET];
  logic [mob_pkg::ALPHABET-1:0] vld_r;
  logic [mob_pkg::CNT_W-1:0]    data_r;
  logic                         rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    data_r   <= mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  // A value never written since the last clear counts as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_count = rd_vld_r ? data_r : '0;

endmodule

### sv/mob_best.sv
module mob_best (
  input  logic                       clk,
  input  logic                       clr,
  input  logic                       en,
  input  logic [mob_pkg::BYTE_W-1:0] char_in,
  input  logic [mob_pkg::CNT_W-1:0]  count_in,
  output logic [mob_pkg::BYTE_W-1:0] best_char,
  output logic [mob_pkg::CNT_W-1:0]  best_count
);

  logic [mob_pkg::BYTE_W-1:0] char_r;
  logic [mob_pkg::CNT_W-1:0]  count_r;

  // Strictly greater keeps the earliest byte on a tie.
  always_ff @(posedge clk) begin
    if (clr) begin
      char_r  <= '0;
      count_r <= '0;
    end else if (en && (count_in > count_r)) begin
      char_r  <= char_in;
      count_r <= count_in;
    end
  end

  assign best_char  = char_r;
  assign best_count = count_r;

endmodule

### sv/max_occurring_byte.sv
// A byte item is read from the histogram while idle, then written back in ST_INC.
// An item marked last starts a walk over the L stored bytes, after its own ST_INC update
// when it carries a byte; each byte is read from the buffer, then its count, then compared.
// A new byte is taken only in ST_IDLE, never while ST_INC writes back the one before.
// Reset is synchronous: control state, string length, overflow flag and histogram valid bits
// clear; the string buffer holds no reset value.
module max_occurring_byte (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tuser,   // [0] has_char
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] max_char, [15:8] max_count
  output logic        out_tuser   // [0] truncated
);

  mob_pkg::state_t state_r, state_nxt;

  logic [mob_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [mob_pkg::LEN_W-1:0]  idx_r, idx_nxt;
  logic                       p1_r, p2_r;
  logic [mob_pkg::BYTE_W-1:0] byte_r;
  logic                       last_r;
  logic [mob_pkg::BYTE_W-1:0] ch2_r;

  logic                       out_valid_r;
  logic [mob_pkg::BYTE_W-1:0] out_char_r;
  logic [mob_pkg::CNT_W-1:0]  out_count_r;
  logic                       out_trunc_r;

  logic                       accept;
  logic                       in_range;
  logic                       room;
  logic                       take;
  logic                       drop;
  logic                       issue;
  logic                       walk_done;
  logic                       load_out;
  logic                       best_clr;

  logic [mob_pkg::BYTE_W-1:0]  buf_rd_data;
  logic [mob_pkg::ALPHA_W-1:0] hist_rd_addr;
  logic [mob_pkg::CNT_W-1:0]   hist_count;
  mob_pkg::hist_wr_t           hist_wr;
  logic [mob_pkg::BYTE_W-1:0]  best_char;
  logic [mob_pkg::CNT_W-1:0]   best_count;

  assign accept   = in_tvalid && in_tready;
  assign in_range = ({1'b0, in_tdata} < (mob_pkg::BYTE_W + 1)'(mob_pkg::ALPHABET));
  assign room     = (len_r < mob_pkg::LEN_W'(mob_pkg::MAX_LEN));
  assign take     = accept && in_tuser && in_range && room;
  assign drop     = accept && in_tuser && in_range && !room;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mob_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = mob_pkg::ST_INC;
        end else if (accept && in_tlast) begin
          state_nxt = mob_pkg::ST_WALK;
        end
      end
      mob_pkg::ST_INC: begin
        state_nxt = last_r ? mob_pkg::ST_WALK : mob_pkg::ST_IDLE;
      end
      mob_pkg::ST_WALK: begin
        if (walk_done) begin
          state_nxt = mob_pkg::ST_DONE;
        end
      end
      mob_pkg::ST_DONE: begin
        if (load_out) begin
          state_nxt = mob_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mob_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_tready    = (state_r == mob_pkg::ST_IDLE);
    issue        = (state_r == mob_pkg::ST_WALK) && (idx_r < len_r);
    walk_done    = (state_r == mob_pkg::ST_WALK) && !issue && !p1_r && !p2_r;
    load_out     = (state_r == mob_pkg::ST_DONE) && (!out_valid_r || out_tready);
    best_clr     = (state_r != mob_pkg::ST_WALK) && (state_nxt == mob_pkg::ST_WALK);
    // While idle the histogram reads the incoming byte; during the walk it reads
    // the byte that the buffer just returned.
    hist_rd_addr = (state_r == mob_pkg::ST_IDLE) ? in_tdata[mob_pkg::ALPHA_W-1:0]
                                                  : buf_rd_data[mob_pkg::ALPHA_W-1:0];
    hist_wr.en   = (state_r == mob_pkg::ST_INC);
    hist_wr.addr = byte_r[mob_pkg::ALPHA_W-1:0];
    hist_wr.data = (hist_count == mob_pkg::CNT_MAX) ? hist_count
                                                     : hist_count + mob_pkg::CNT_W'(1);
  end

  always_comb begin
    len_nxt = len_r;
    ovf_nxt = ovf_r;
    idx_nxt = idx_r;
    if (take) begin
      len_nxt = len_r + mob_pkg::LEN_W'(1);
    end
    if (drop) begin
      ovf_nxt = 1'b1;
    end
    if (best_clr) begin
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + mob_pkg::LEN_W'(1);
    end
    if (load_out) begin
      len_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mob_pkg::ST_IDLE;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      idx_r   <= idx_nxt;
      p1_r    <= issue;
      p2_r    <= p1_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
    ch2_r <= buf_rd_data;
    if (load_out) begin
      out_char_r  <= best_char;
      out_count_r <= best_count;
      out_trunc_r <= ovf_r;
    end
  end

  mob_buf u_buf (
    .clk     (clk),
    .wr_en   (take),
    .wr_addr (len_r[mob_pkg::IDX_W-1:0]),
    .wr_data (in_tdata),
    .rd_addr (idx_r[mob_pkg::IDX_W-1:0]),
    .rd_data (buf_rd_data)
  );

  mob_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (load_out),
    .rd_addr  (hist_rd_addr),
    .wr       (hist_wr),
    .rd_count (hist_count)
  );

  mob_best u_best (
    .clk        (clk),
    .clr        (best_clr),
    .en         (p2_r),
    .char_in    (ch2_r),
    .count_in   (hist_count),
    .best_char  (best_char),
    .best_count (best_count)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_char_r};
  assign out_tuser  = out_trunc_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= mob_pkg::LEN_W'(mob_pkg::MAX_LEN))
    else $error("string length beyond buffer size");

  assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (state_r == mob_pkg::ST_INC))
    else $error("stored byte not followed by histogram update");

  assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (len_r == '0) && !ovf_r && out_tvalid)
    else $error("string state not cleared after result");

  assert property (@(posedge clk) disable iff (!rst_n)
    p2_r |-> $past(p1_r))
    else $error("walk pipeline out of step");

endmodule
